### sv/adamw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_pkg
// Shared types, register codes, reset values and helpers for the AdamW
// parameter update pipeline.
// ----------------------------------------------------------------------------
package adamw_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned REG_IDX_W       = 3;
	localparam int unsigned STEPS_PER_STAGE = 2;
	localparam int unsigned SQRT_STAGES     = DATA_W / STEPS_PER_STAGE;
	localparam int unsigned DIV_STAGES      = DATA_W / STEPS_PER_STAGE;
	// four front stages, root stages, one check stage, divide stages, three tail stages
	localparam int unsigned LATENCY         = 4 + SQRT_STAGES + 1 + DIV_STAGES + 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LR    = 3'd0,
		REG_BETA1 = 3'd1,
		REG_BETA2 = 3'd2,
		REG_EPS   = 3'd3,
		REG_WD    = 3'd4,
		REG_BIAS1 = 3'd5,
		REG_BIAS2 = 3'd6
	} reg_idx_t;

	localparam logic [DATA_W-1:0] LR_RESET    = 32'd4294967;
	localparam logic [DATA_W-1:0] BETA1_RESET = 32'd3865470566;
	localparam logic [DATA_W-1:0] BETA2_RESET = 32'd4290672329;
	localparam logic [DATA_W-1:0] EPS_RESET   = 32'd43;
	localparam logic [DATA_W-1:0] WD_RESET    = 32'd0;
	localparam logic [DATA_W-1:0] BIAS1_RESET = 32'd65536;
	localparam logic [DATA_W-1:0] BIAS2_RESET = 32'd65536;

	localparam logic signed [DATA_W-1:0] SMAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SMIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] weight;
		logic signed [31:0] gradient;
		logic signed [31:0] first_moment;
		logic        [31:0] second_moment;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] new_weight;
		logic signed [31:0] new_first_moment;
		logic        [31:0] new_second_moment;
	} out_beat_t;

	// values that ride along with the long root and divide sections
	typedef struct packed {
		logic signed [31:0] weight;
		logic signed [31:0] decay;
		logic signed [31:0] m_new;
		logic        [31:0] v_new;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic signed [47:0] mhat;
		logic        [63:0] rad;
		logic        [34:0] rem;
		logic        [31:0] root;
	} sqrt_t;

	typedef struct packed {
		side_t       side;
		logic        neg;
		logic        zero;
		logic        ovf;
		logic [48:0] den;
		logic [49:0] rem;
		logic [31:0] quo;
	} div_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [31:0] r;
		if (x > 66'(SMAX)) begin
			r = SMAX;
		end else if (x < 66'(SMIN)) begin
			r = SMIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/adamw_parameter_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_parameter_update
// Streaming AdamW update of one weight element per beat, fixed point.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  command   start, busy, args                in         start && !busy
//  result    done, result                     out        done, one cycle
//  config    wr_en, wr_index, wr_data         in         wr_en
//
//  A beat enters every cycle; busy stays low. Results leave in command
//  order; their delay is set by the square root and the divider, each
//  resolving two bits per stage over sixteen stages.
//  Reset clears the valid bits and loads the register reset values.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module adamw_parameter_update (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  adamw_pkg::in_beat_t    args,
	output logic                   done,
	output adamw_pkg::out_beat_t   result,
	input  wire                    wr_en,
	input  wire [2:0]              wr_index,
	input  wire [31:0]             wr_data
);
	import adamw_pkg::*;

	// configuration registers
	logic [31:0] lr_q, beta1_q, beta2_q, eps_q, wd_q, bias1_q, bias2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= LR_RESET;
			beta1_q <= BETA1_RESET;
			beta2_q <= BETA2_RESET;
			eps_q   <= EPS_RESET;
			wd_q    <= WD_RESET;
			bias1_q <= BIAS1_RESET;
			bias2_q <= BIAS2_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LR:    lr_q    <= wr_data;
				REG_BETA1: beta1_q <= wr_data;
				REG_BETA2: beta2_q <= wr_data;
				REG_EPS:   eps_q   <= wr_data;
				REG_WD:    wd_q    <= wr_data;
				REG_BIAS1: bias1_q <= wr_data;
				REG_BIAS2: bias2_q <= wr_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	assign busy = 1'b0;

	logic in_fire;
	assign in_fire = start && !busy;

	// ---------------- stage 1: first products ----------------
	// one minus beta is 2^32 - beta, so a beta of zero means 1.0
	logic        [32:0] c1;
	logic        [31:0] ag;
	logic signed [64:0] pm_s1, pd_s1;
	logic signed [65:0] pg_s1;
	logic        [63:0] gsq_s1;
	logic signed [31:0] w_s1;
	logic        [31:0] v_s1;
	logic               vld_s1;

	assign c1 = {1'b1, 32'd0} - {1'b0, beta1_q};
	assign ag = args.gradient[31] ? 32'(-args.gradient) : args.gradient;

	always_ff @(posedge clk) begin
		pm_s1  <= $signed({1'b0, beta1_q}) * args.first_moment;
		pg_s1  <= $signed({1'b0, c1}) * args.gradient;
		pd_s1  <= $signed({1'b0, wd_q}) * args.weight;
		gsq_s1 <= ag * ag;
		w_s1   <= args.weight;
		v_s1   <= args.second_moment;
	end

	// ---------------- stage 2: new first moment, second moment products ----------------
	logic        [32:0] c2;
	logic        [47:0] g2;
	logic signed [65:0] macc;
	logic signed [31:0] m_new_s2, w_s2, decay_s2;
	logic        [63:0] a1_s2;
	logic        [64:0] a2_s2;
	logic        [48:0] a3_s2;
	logic               vld_s2;

	assign c2   = {1'b1, 32'd0} - {1'b0, beta2_q};
	assign g2   = gsq_s1[63:16];
	assign macc = 66'(pm_s1) + pg_s1;

	always_ff @(posedge clk) begin
		m_new_s2 <= sat32(macc >>> 32);
		a1_s2    <= beta2_q * v_s1;
		a2_s2    <= c2 * g2[31:0];
		a3_s2    <= c2 * g2[47:32];
		w_s2     <= w_s1;
		decay_s2 <= pd_s1[63:32];
	end

	// ---------------- stage 3: new second moment, first bias product ----------------
	logic        [65:0] vsum;
	logic        [48:0] vtot;
	logic        [31:0] v_new_s3;
	logic signed [64:0] mprod_s3;
	logic signed [31:0] m_new_s3, w_s3, decay_s3;
	logic               vld_s3;

	assign vsum = 66'(a1_s2) + 66'(a2_s2);
	assign vtot = 49'(vsum[65:32]) + a3_s2;

	always_ff @(posedge clk) begin
		v_new_s3 <= (|vtot[48:32]) ? 32'hFFFF_FFFF : vtot[31:0];
		mprod_s3 <= m_new_s2 * $signed({1'b0, bias1_q});
		m_new_s3 <= m_new_s2;
		w_s3     <= w_s2;
		decay_s3 <= decay_s2;
	end

	// ---------------- stage 4: bias corrected estimates ----------------
	logic signed [47:0] mhat_s4;
	logic        [63:0] vprod_s4;
	side_t              side_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		mhat_s4        <= mprod_s3[63:16];
		vprod_s4       <= v_new_s3 * bias2_q;
		side_s4.weight <= w_s3;
		side_s4.decay  <= decay_s3;
		side_s4.m_new  <= m_new_s3;
		side_s4.v_new  <= v_new_s3;
	end

	// ---------------- stages 5..20: integer square root, two bits a stage ----------------
	sqrt_t sqrt_s     [SQRT_STAGES];
	logic  sqrt_vld_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		sqrt_t cur, nxt;
		logic  cur_vld;

		if (k == 0) begin : g_first
			// radicand is vhat shifted up by 16, i.e. vprod with its low bits cleared
			assign cur.side = side_s4;
			assign cur.mhat = mhat_s4;
			assign cur.rad  = {vprod_s4[63:16], 16'd0};
			assign cur.rem  = '0;
			assign cur.root = '0;
			assign cur_vld  = vld_s4;
		end else begin : g_rest
			assign cur     = sqrt_s[k-1];
			assign cur_vld = sqrt_vld_s[k-1];
		end

		always_comb begin : p_step
			logic [34:0] r;
			logic [34:0] trial;
			logic [34:0] rem;
			logic [31:0] root;
			nxt  = cur;
			rem  = cur.rem;
			root = cur.root;
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				r     = {rem[32:0], cur.rad[63 - 2*(STEPS_PER_STAGE*k + t) -: 2]};
				trial = {1'b0, root, 2'b01};
				if (r >= trial) begin
					rem  = r - trial;
					root = {root[30:0], 1'b1};
				end else begin
					rem  = r;
					root = {root[30:0], 1'b0};
				end
			end
			nxt.rem  = rem;
			nxt.root = root;
		end

		always_ff @(posedge clk) begin
			sqrt_s[k] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_vld_s[k] <= 1'b0;
			end else begin
				sqrt_vld_s[k] <= cur_vld;
			end
		end
	end

	// ---------------- stage 21: denominator and range check ----------------
	sqrt_t       sq_last;
	logic [48:0] den;
	logic [47:0] am;
	div_t        chk_s21;
	logic        vld_s21;

	assign sq_last = sqrt_s[SQRT_STAGES-1];
	assign den     = 49'({sq_last.root, 16'd0}) + 49'(eps_q);
	assign am      = sq_last.mhat[47] ? 48'(-sq_last.mhat) : sq_last.mhat;

	always_ff @(posedge clk) begin
		chk_s21.side <= sq_last.side;
		chk_s21.neg  <= sq_last.mhat[47];
		chk_s21.zero <= (sq_last.mhat == '0);
		// quotient would not fit, or the denominator is zero: saturate
		chk_s21.ovf  <= ({am, 1'b0} >= den);
		chk_s21.den  <= den;
		chk_s21.rem  <= 50'(am);
		chk_s21.quo  <= '0;
	end

	// ---------------- stages 22..37: restoring divide, two bits a stage ----------------
	div_t div_s     [DIV_STAGES];
	logic div_vld_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_t cur, nxt;
		logic cur_vld;

		if (k == 0) begin : g_first
			assign cur     = chk_s21;
			assign cur_vld = vld_s21;
		end else begin : g_rest
			assign cur     = div_s[k-1];
			assign cur_vld = div_vld_s[k-1];
		end

		always_comb begin : p_step
			logic [49:0] r;
			logic [31:0] q;
			nxt = cur;
			r   = cur.rem;
			q   = cur.quo;
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				r = {r[48:0], 1'b0};
				if (r >= {1'b0, cur.den}) begin
					r = r - {1'b0, cur.den};
					q = {q[30:0], 1'b1};
				end else begin
					q = {q[30:0], 1'b0};
				end
			end
			nxt.rem = r;
			nxt.quo = q;
		end

		always_ff @(posedge clk) begin
			div_s[k] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else begin
				div_vld_s[k] <= cur_vld;
			end
		end
	end

	// ---------------- stage 38: ratio plus decay ----------------
	div_t               dv_last;
	logic signed [32:0] sq;
	logic signed [31:0] ratio;
	logic signed [31:0] sum_s38, w_s38, m_new_s38;
	logic        [31:0] v_new_s38;
	logic               vld_s38;

	assign dv_last = div_s[DIV_STAGES-1];
	assign sq = dv_last.neg ? -$signed({1'b0, dv_last.quo}) : $signed({1'b0, dv_last.quo});

	always_comb begin
		if (dv_last.zero) begin
			ratio = '0;
		end else if (dv_last.ovf) begin
			ratio = dv_last.neg ? SMIN : SMAX;
		end else begin
			ratio = sat32(66'(sq));
		end
	end

	always_ff @(posedge clk) begin
		sum_s38   <= sat32(66'(ratio) + 66'(dv_last.side.decay));
		w_s38     <= dv_last.side.weight;
		m_new_s38 <= dv_last.side.m_new;
		v_new_s38 <= dv_last.side.v_new;
	end

	// ---------------- stage 39: learning rate product ----------------
	logic signed [64:0] stp_s39;
	logic signed [31:0] w_s39, m_new_s39;
	logic        [31:0] v_new_s39;
	logic               vld_s39;

	always_ff @(posedge clk) begin
		stp_s39   <= $signed({1'b0, lr_q}) * sum_s38;
		w_s39     <= w_s38;
		m_new_s39 <= m_new_s38;
		v_new_s39 <= v_new_s38;
	end

	// ---------------- stage 40: weight update, output register ----------------
	logic signed [31:0] stepv;
	out_beat_t          res_s40;
	logic               vld_s40;

	assign stepv = stp_s39[63:32];

	always_ff @(posedge clk) begin
		res_s40.new_weight        <= sat32(66'(w_s39) - 66'(stepv));
		res_s40.new_first_moment  <= m_new_s39;
		res_s40.new_second_moment <= v_new_s39;
	end

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s21 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
		end else begin
			vld_s1  <= in_fire;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s21 <= sqrt_vld_s[SQRT_STAGES-1];
			vld_s38 <= div_vld_s[DIV_STAGES-1];
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
		end
	end

	assign done   = vld_s40;
	assign result = res_s40;

endmodule
`default_nettype wire

### sv/adamw_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adamw_chk
// Port-level checks of the AdamW update pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module adamw_chk (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  start,
	input wire                  busy,
	input adamw_pkg::in_beat_t  args,
	input wire                  done,
	input adamw_pkg::out_beat_t result
);
	import adamw_pkg::*;

	// every command beat yields a result beat after a fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result beat missing after command beat");

	// no result beat without a command beat at the matching cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without command beat");

	// zero gradient and zero first moment keep the first moment at zero
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && args.gradient == '0 && args.first_moment == '0)
		|-> ##LATENCY (result.new_first_moment == '0))
		else $error("first moment moved from zero");

	// zero gradient and zero second moment keep the second moment at zero
	a_second_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && args.gradient == '0 && args.second_moment == '0)
		|-> ##LATENCY (result.new_second_moment == '0))
		else $error("second moment moved from zero");

endmodule

bind adamw_parameter_update adamw_chk u_adamw_chk (.*);
`default_nettype wire

### tb/adamw_parameter_update_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adamw_parameter_update_test
// Self-checking bench for the AdamW update pipeline: drives command beats
// under several register settings and idle patterns, predicts every result
// in fixed point and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module adamw_parameter_update_test;
	import adamw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	// index past the register list; the block must ignore writes to it
	localparam logic [2:0] REG_UNUSED = 3'd7;

	// Hold the register copy and the in-order queue of expected results.
	class update_scoreboard;
		logic [31:0] regs[7];
		out_beat_t   pending[$];
		int          errors;

		function new();
			regs[REG_LR]    = LR_RESET;
			regs[REG_BETA1] = BETA1_RESET;
			regs[REG_BETA2] = BETA2_RESET;
			regs[REG_EPS]   = EPS_RESET;
			regs[REG_WD]    = WD_RESET;
			regs[REG_BIAS1] = BIAS1_RESET;
			regs[REG_BIAS2] = BIAS2_RESET;
			errors = 0;
		endfunction

		function automatic logic signed [127:0] clamp(logic signed [127:0] x);
			logic signed [127:0] r;
			r = x;
			if (x > 128'sh7FFF_FFFF) r = 128'sh7FFF_FFFF;
			if (x < -128'sh8000_0000) r = -128'sh8000_0000;
			return r;
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] x);
			logic [63:0] res, b;
			res = '0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= res + b) begin
					x = x - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Compute the updated weight and moments for one command beat.
		function automatic out_beat_t adamw_update(in_beat_t a);
			logic signed [127:0] w, g, m, mn, mh, ratio, dec, sum, stp, wn;
			logic [127:0] c1, c2, ag, g2, vn, vh, den, am, q;
			logic [63:0] root;
			out_beat_t o;
			w = a.weight;
			g = a.gradient;
			m = a.first_moment;
			c1 = 128'h1_0000_0000 - regs[REG_BETA1];
			c2 = 128'h1_0000_0000 - regs[REG_BETA2];
			mn = clamp(($signed({96'd0, regs[REG_BETA1]}) * m + $signed(c1) * g) >>> 32);
			ag = (g < 0) ? -g : g;
			g2 = (ag * ag) >> 16;
			vn = (regs[REG_BETA2] * {96'd0, a.second_moment} + c2 * g2) >> 32;
			if (vn > 128'hFFFF_FFFF) vn = 128'hFFFF_FFFF;
			mh = (mn * $signed({96'd0, regs[REG_BIAS1]})) >>> 16;
			vh = (vn * regs[REG_BIAS2]) >> 16;
			root = int_sqrt(64'(vh << 16));
			den = {48'd0, root, 16'd0} + regs[REG_EPS];
			if (mh == 0) begin
				ratio = 0;
			end else begin
				am = (mh < 0) ? -mh : mh;
				if (2 * am >= den) begin
					ratio = (mh < 0) ? -128'sh8000_0000 : 128'sh7FFF_FFFF;
				end else begin
					q = (am << 32) / den;
					ratio = (mh < 0) ? -$signed(q) : $signed(q);
				end
			end
			dec = ($signed({96'd0, regs[REG_WD]}) * w) >>> 32;
			sum = clamp(ratio + dec);
			stp = ($signed({96'd0, regs[REG_LR]}) * sum) >>> 32;
			wn = clamp(w - stp);
			o.new_weight = wn[31:0];
			o.new_first_moment = mn[31:0];
			o.new_second_moment = vn[31:0];
			return o;
		endfunction

		function void note_command(in_beat_t a);
			pending.push_back(adamw_update(a));
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(out_beat_t r);
			out_beat_t e;
			if (pending.size() == 0) begin
				report("result beat with nothing pending");
			end else begin
				e = pending.pop_front();
				if (r.new_weight !== e.new_weight)
					report($sformatf("new_weight %h, want %h", r.new_weight, e.new_weight));
				if (r.new_first_moment !== e.new_first_moment)
					report($sformatf("new_first_moment %h, want %h",
						r.new_first_moment, e.new_first_moment));
				if (r.new_second_moment !== e.new_second_moment)
					report($sformatf("new_second_moment %h, want %h",
						r.new_second_moment, e.new_second_moment));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	in_beat_t   args;
	logic       done;
	out_beat_t  result;
	logic       wr_en;
	logic [2:0] wr_index;
	logic [31:0] wr_data;

	update_scoreboard sb = new();
	int unsigned cycles = 0;
	int idle_pct = 0;

	adamw_parameter_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .args(args),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Note accepted command beats and check result beats on the edge that takes them.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy) sb.note_command(args);
			if (done) sb.check_result(result);
		end
	end

	// Write one register while the pipeline is empty; mirror it in the scoreboard.
	task write_reg(logic [2:0] idx, logic [31:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx != REG_UNUSED) sb.regs[idx] = val;
	endtask

	// Drain: wait for every pending result, then let the pipeline settle.
	task drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task load_regs(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2, logic [31:0] eps,
		logic [31:0] wd, logic [31:0] s1, logic [31:0] s2);
		write_reg(REG_LR, lr);
		write_reg(REG_BETA1, b1);
		write_reg(REG_BETA2, b2);
		write_reg(REG_EPS, eps);
		write_reg(REG_WD, wd);
		write_reg(REG_BIAS1, s1);
		write_reg(REG_BIAS2, s2);
	endtask

	// Send one command beat; optionally idle first, then hold start until taken.
	task send_beat(in_beat_t a);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		args <= a;
		do @(posedge clk); while (busy);
	endtask

	task send_fields(logic [31:0] w, logic [31:0] g, logic [31:0] m, logic [31:0] v);
		in_beat_t a;
		a.weight = w;
		a.gradient = g;
		a.first_moment = m;
		a.second_moment = v;
		send_beat(a);
	endtask

	// Mix full-range words with small magnitudes so ratios do not always clamp.
	function automatic logic [31:0] pick_signed();
		logic [31:0] r;
		case ($urandom_range(3))
			0: r = $urandom;
			1: r = $urandom_range(32'h000F_FFFF);
			2: r = -$urandom_range(32'h000F_FFFF);
			default: r = $urandom_range(32'h3FF);
		endcase
		return r;
	endfunction

	task random_phase(int n, int pct);
		in_beat_t a;
		idle_pct = pct;
		repeat (n) begin
			a.weight = pick_signed();
			a.gradient = pick_signed();
			a.first_moment = pick_signed();
			a.second_moment = ($urandom_range(1)) ? $urandom : $urandom_range(32'h00FF_FFFF);
			send_beat(a);
		end
		start <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		args = '0;
		wr_en = 1'b0;
		wr_index = REG_LR;
		wr_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values first, then zero epsilon for the zero-denominator cases.
		send_fields(32'h0001_0000, 32'h0000_8000, 32'h0000_1000, 32'h0000_0100);
		start <= 1'b0;
		drain();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_EPS, 32'd0);
		// zero denominator with zero and nonzero numerator, both signs
		send_fields(32'h0001_0000, 32'd0, 32'd0, 32'd0);
		send_fields(32'h0001_0000, 32'd0, 32'h0010_0000, 32'd0);
		send_fields(32'hFFFF_0000, 32'd0, 32'hFFF0_0000, 32'd0);
		// extremes of every field
		send_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		send_fields(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1);
		send_fields(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0);
		// large ratio: big first moment over a tiny second moment
		send_fields(32'd0, 32'd0, 32'h4000_0000, 32'd1);
		send_fields(32'd0, 32'd0, 32'hC000_0000, 32'd1);
		start <= 1'b0;
		drain();
		// all registers at their ceiling
		load_regs('1, '1, '1, '1, '1, '1, '1);
		send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		send_fields(32'h0001_0000, 32'h0000_0400, 32'hFFFF_0000, 32'h0000_0010);
		start <= 1'b0;
		drain();
		// all registers at zero: beta of zero weighs the gradient fully
		load_regs('0, '0, '0, '0, '0, '0, '0);
		send_fields(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_fields(32'h8000_0000, 32'h0001_0000, 32'd0, 32'd0);
		start <= 1'b0;
		drain();

		// Random phases: sender idles 29%, then 46%, then not at all.
		load_regs(LR_RESET, BETA1_RESET, BETA2_RESET, EPS_RESET, 32'h0100_0000,
			32'h0001_8000, 32'h0002_0000);
		random_phase(250, 29);
		load_regs($urandom, $urandom, $urandom, $urandom_range(32'hFFFF), $urandom,
			$urandom_range(32'h0001_0000, 32'h0010_0000),
			$urandom_range(32'h0001_0000, 32'h0010_0000));
		random_phase(250, 29);
		load_regs('1, '1, '1, '1, '1, '1, '1);
		random_phase(250, 46);
		load_regs(32'h0800_0000, 32'hE666_6666, 32'hFFBE_76C9, 32'd0, 32'h0001_0000,
			32'h000A_0000, 32'h03E8_0000);
		random_phase(250, 46);
		load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		random_phase(250, 0);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
sv/adamw_pkg.sv
sv/adamw_parameter_update.sv
sv/adamw_chk.sv
tb/adamw_parameter_update_test.sv
